@@ sv/clte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clte_pkg
// Shared types and constants for the cursor list tape engine.
// ----------------------------------------------------------------------------
package clte_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OP_W         = 3;
  localparam int ELEM_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int IN_W         = ((OP_W + ELEM_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_REWIND    = 3'd0,
    OP_STEP      = 3'd1,
    OP_INS_LEFT  = 3'd2,
    OP_INS_RIGHT = 3'd3,
    OP_ERASE     = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_AT_STOP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_VAL
  } state_t;

endpackage

@@ sv/cursor_list_tape_engine_core.sv @@
`timescale 1ns / 1ps
// From input accept to m_tvalid an item passes execute, second link write and value read.
// Items never overlap: a new one is taken in S_IDLE, or in S_VAL once the output is
// free: two link writes share one next-pointer port, then the new cursor's value is read.
// Reset: synchronous; clears head, cursor, predecessor, free list, fresh counter and length.
// The node pool memories are not cleared; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// cursor_list_tape_engine_core
// Byte tape kept as a singly linked list in a node pool with a cursor and a
// predecessor pointer; rewind, step, insert left/right, erase and read.
// ----------------------------------------------------------------------------
module cursor_list_tape_engine_core
  import clte_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int PTR_W   = $clog2(CAPACITY + 1),
  localparam int OUT_W   = ((ELEM_W + STATUS_W + PTR_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op, elem
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // cur_elem, status, length, at_start, at_stop
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  state_t state, state_next;

  logic [OP_W-1:0]   op_q;
  logic [ELEM_W-1:0] elem_q;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] cursor, cursor_next;
  logic [PTR_W-1:0] pred, pred_next;
  logic [PTR_W-1:0] free_head, free_next;
  logic [PTR_W-1:0] fresh_count, fresh_next;
  logic [PTR_W-1:0] count, count_next;
  status_t          status_q, status_next;

  logic [PTR_W-1:0]  next_mem [CAPACITY];
  logic [ELEM_W-1:0] val_mem  [CAPACITY];
  logic [PTR_W-1:0]  nxt_a_q;
  logic [PTR_W-1:0]  nxt_b_q;
  logic [ELEM_W-1:0] val_q;

  logic             w1_en;
  logic [IDX_W-1:0] w1_addr;
  logic [PTR_W-1:0] w1_data;
  logic             w2_en, w2_en_next;
  logic [IDX_W-1:0] w2_addr, w2_addr_next;
  logic [PTR_W-1:0] w2_data, w2_data_next;
  logic             vw_en;
  logic             nw_en;
  logic [IDX_W-1:0] nw_addr;
  logic [PTR_W-1:0] nw_data;

  logic             exec_en, link_en, out_load, out_free;
  logic             cur_valid, head_valid, have_free, have_fresh, take;
  logic [PTR_W-1:0] alloc_ptr;

  assign out_free   = !m_tvalid || m_tready;
  assign cur_valid  = (cursor != NIL);
  assign head_valid = (head != NIL);
  assign have_free  = (free_head != NIL);
  assign have_fresh = (fresh_count < NIL);
  assign alloc_ptr  = have_free ? free_head : fresh_count;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_LINK;
      S_LINK: state_next = S_VAL;
      S_VAL: begin
        if (out_free) state_next = s_tvalid ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State-machine outputs
  always_comb begin
    s_tready = 1'b0;
    exec_en  = 1'b0;
    link_en  = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_EXEC: exec_en  = 1'b1;
      S_LINK: link_en  = 1'b1;
      S_VAL: begin
        s_tready = out_free;
        out_load = out_free;
      end
      default: s_tready = 1'b0;
    endcase
  end

  // Command execution: nxt_a_q = next of cursor, nxt_b_q = next of free head
  always_comb begin
    head_next    = head;
    cursor_next  = cursor;
    pred_next    = pred;
    free_next    = free_head;
    fresh_next   = fresh_count;
    count_next   = count;
    status_next  = ST_OK;
    take         = 1'b0;
    vw_en        = 1'b0;
    w1_en        = 1'b0;
    w1_addr      = alloc_ptr[IDX_W-1:0];
    w1_data      = NIL;
    w2_en_next   = 1'b0;
    w2_addr_next = pred[IDX_W-1:0];
    w2_data_next = alloc_ptr;
    case (op_q)
      OP_REWIND: begin
        cursor_next = head;
        pred_next   = NIL;
      end
      OP_STEP: begin
        if (cur_valid) begin
          pred_next   = cursor;
          cursor_next = nxt_a_q;
        end
      end
      OP_INS_LEFT: begin
        if (!have_free && !have_fresh) begin
          status_next = ST_FULL;
        end else begin
          take    = 1'b1;
          vw_en   = 1'b1;
          w1_en   = 1'b1;
          w1_data = cursor;
          if (cursor == head) begin
            head_next = alloc_ptr;
            pred_next = NIL;
          end else begin
            w2_en_next = (pred != NIL);
          end
          cursor_next = alloc_ptr;
          count_next  = count + PTR_W'(1);
        end
      end
      OP_INS_RIGHT: begin
        if (!cur_valid && head_valid) begin
          status_next = ST_AT_STOP;
        end else if (!have_free && !have_fresh) begin
          status_next = ST_FULL;
        end else begin
          take  = 1'b1;
          vw_en = 1'b1;
          w1_en = 1'b1;
          if (head_valid) begin
            // cursor is valid here: splice after it
            w1_data      = nxt_a_q;
            w2_en_next   = 1'b1;
            w2_addr_next = cursor[IDX_W-1:0];
            pred_next    = cursor;
          end else begin
            head_next = alloc_ptr;
            pred_next = NIL;
          end
          cursor_next = alloc_ptr;
          count_next  = count + PTR_W'(1);
        end
      end
      OP_ERASE: begin
        if (!cur_valid) begin
          status_next = ST_AT_STOP;
        end else begin
          if (cursor == head) begin
            head_next = nxt_a_q;
            pred_next = NIL;
          end else begin
            w1_en   = (pred != NIL);
            w1_addr = pred[IDX_W-1:0];
            w1_data = nxt_a_q;
          end
          cursor_next = nxt_a_q;
          // push the erased node on the free list
          w2_en_next   = 1'b1;
          w2_addr_next = cursor[IDX_W-1:0];
          w2_data_next = free_head;
          free_next    = cursor;
          if (count != '0) count_next = count - PTR_W'(1);
        end
      end
      OP_READ: begin
        if (!cur_valid) status_next = ST_AT_STOP;
      end
      default: status_next = ST_OK;
    endcase
    if (take) begin
      if (have_free) free_next = nxt_b_q;
      else fresh_next = fresh_count + PTR_W'(1);
    end
  end

  assign nw_en   = (exec_en && w1_en) || (link_en && w2_en);
  assign nw_addr = exec_en ? w1_addr : w2_addr;
  assign nw_data = exec_en ? w1_data : w2_data;

  // Next-pointer memory: one write port, two read ports
  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    nxt_a_q <= next_mem[cursor[IDX_W-1:0]];
    nxt_b_q <= next_mem[free_head[IDX_W-1:0]];
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (exec_en && vw_en) val_mem[alloc_ptr[IDX_W-1:0]] <= elem_q;
    val_q <= val_mem[cursor[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tdata[OP_W-1:0];
      elem_q <= s_tdata[OP_W +: ELEM_W];
    end
    if (exec_en) begin
      w2_addr  <= w2_addr_next;
      w2_data  <= w2_data_next;
      status_q <= status_next;
    end
    if (out_load) begin
      m_tdata <= OUT_W'({(cursor == NIL), (cursor == head), count, status_q,
                         (cursor != NIL) ? val_q : ELEM_W'(0)});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= NIL;
      cursor      <= NIL;
      pred        <= NIL;
      free_head   <= NIL;
      fresh_count <= '0;
      count       <= '0;
      w2_en       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_en) begin
        head        <= head_next;
        cursor      <= cursor_next;
        pred        <= pred_next;
        free_head   <= free_next;
        fresh_count <= fresh_next;
        count       <= count_next;
        w2_en       <= w2_en_next;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("length exceeds pool capacity");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (count == '0))
    else $error("head pointer and length disagree");

  a_pred_at_head: assert property (@(posedge clk) disable iff (rst)
    (cursor == head && head != NIL) |-> pred == NIL)
    else $error("predecessor set while cursor is on the first node");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC || state == S_LINK) |-> !s_tready)
    else $error("item accepted while links are being written");
`endif

endmodule

@@ verif/cursor_list_tape_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_tape_engine_core_tb
// Drives tape commands (rewind, step, insert left/right, erase, read) through
// the stream ports and checks every report against a local list-and-cursor
// model. A short directed table covers the empty tape, stepping past the stop
// and the at-stop errors; random phases then fill the pool to exhaustion,
// drain it, and wander. Both sides idle at random; the receiver also holds
// off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module cursor_list_tape_engine_core_tb;
  import clte_pkg::*;

  localparam int          PTR_W       = 9;
  localparam int          OUT_W       = 24;
  localparam logic [8:0]  NIL         = 9'(CAPACITY_DEF);
  localparam logic [2:0]  OP_UNDEF_LO = 3'd6;
  localparam logic [2:0]  OP_UNDEF_HI = 3'd7;
  localparam int          FILL_ITEMS  = 450;
  localparam int          DRAIN_ITEMS = 400;
  localparam int          RAND_ITEMS  = 1830;
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 400;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          NUM_ROWS    = 23;

  typedef struct packed {
    logic             at_stop;
    logic             at_start;
    logic [PTR_W-1:0] length;
    status_t          status;
    logic [7:0]       cur_elem;
  } tape_report_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [7:0]   elem;
    logic         typed;
    tape_report_t want;
  } tape_cmd_row_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_NAV, MIX_ANY} cmd_mix_t;

  localparam tape_report_t NO_REPORT = '{1'b0, 1'b0, 9'd0, ST_OK, 8'h00};

  // Typed reports only where they are obvious: empty tape and stop errors.
  localparam tape_cmd_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_READ,      8'h00, 1'b1, '{1'b1, 1'b1, 9'd0, ST_AT_STOP, 8'h00}},
    '{OP_ERASE,     8'h00, 1'b1, '{1'b1, 1'b1, 9'd0, ST_AT_STOP, 8'h00}},
    '{OP_STEP,      8'h00, 1'b1, '{1'b1, 1'b1, 9'd0, ST_OK, 8'h00}},
    '{OP_REWIND,    8'h00, 1'b1, '{1'b1, 1'b1, 9'd0, ST_OK, 8'h00}},
    '{OP_INS_RIGHT, 8'hFF, 1'b1, '{1'b0, 1'b1, 9'd1, ST_OK, 8'hFF}},
    '{OP_INS_RIGHT, 8'h00, 1'b0, NO_REPORT},
    '{OP_STEP,      8'h00, 1'b0, NO_REPORT},
    '{OP_STEP,      8'h00, 1'b0, NO_REPORT},
    '{OP_INS_RIGHT, 8'h3C, 1'b1, '{1'b1, 1'b0, 9'd2, ST_AT_STOP, 8'h00}},
    '{OP_READ,      8'h00, 1'b0, NO_REPORT},
    '{OP_ERASE,     8'h00, 1'b0, NO_REPORT},
    '{OP_INS_LEFT,  8'hA5, 1'b0, NO_REPORT},
    '{OP_REWIND,    8'h00, 1'b0, NO_REPORT},
    '{OP_INS_LEFT,  8'h5A, 1'b0, NO_REPORT},
    '{OP_READ,      8'h00, 1'b0, NO_REPORT},
    '{OP_UNDEF_LO,  8'h77, 1'b0, NO_REPORT},
    '{OP_UNDEF_HI,  8'h88, 1'b0, NO_REPORT},
    '{OP_STEP,      8'h00, 1'b0, NO_REPORT},
    '{OP_ERASE,     8'h00, 1'b0, NO_REPORT},
    '{OP_REWIND,    8'h00, 1'b0, NO_REPORT},
    '{OP_ERASE,     8'h00, 1'b0, NO_REPORT},
    '{OP_STEP,      8'h00, 1'b0, NO_REPORT},
    '{OP_ERASE,     8'h00, 1'b0, NO_REPORT}
  };

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [15:0]      s_tdata;   // op, elem
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // cur_elem, status, length, at_start, at_stop

  cursor_list_tape_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Model of the tape: node pool, free list and cursor.
  logic [PTR_W-1:0] pool_next [CAPACITY_DEF];
  logic [7:0]       pool_val  [CAPACITY_DEF];
  logic [PTR_W-1:0] head_q  = NIL;
  logic [PTR_W-1:0] cur_q   = NIL;
  logic [PTR_W-1:0] pred_q  = NIL;
  logic [PTR_W-1:0] free_q  = NIL;
  logic [PTR_W-1:0] fresh_q = '0;
  logic [PTR_W-1:0] len_q   = '0;

  tape_report_t tape_reports_q [$];
  int           mismatch_count = 0;
  int           idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Reuse the free list first, then hand out fresh nodes in order.
  function automatic logic [PTR_W-1:0] grab_node(logic [7:0] e);
    logic [PTR_W-1:0] n;
    if (free_q != NIL) begin
      n      = free_q;
      free_q = pool_next[n];
    end else if (fresh_q != NIL) begin
      n       = fresh_q;
      fresh_q = fresh_q + PTR_W'(1);
    end else begin
      return NIL;
    end
    pool_val[n]  = e;
    pool_next[n] = NIL;
    return n;
  endfunction

  function automatic tape_report_t apply_tape_cmd(logic [2:0] op, logic [7:0] e);
    tape_report_t     r;
    logic [PTR_W-1:0] n;
    r.status = ST_OK;
    case (op)
      OP_REWIND: begin
        cur_q  = head_q;
        pred_q = NIL;
      end
      OP_STEP: begin
        if (cur_q != NIL) begin
          pred_q = cur_q;
          cur_q  = pool_next[cur_q];
        end
      end
      OP_INS_LEFT: begin
        n = grab_node(e);
        if (n == NIL) begin
          r.status = ST_FULL;
        end else begin
          pool_next[n] = cur_q;
          if (cur_q == head_q) begin
            head_q = n;
            pred_q = NIL;
          end else if (pred_q != NIL) begin
            pool_next[pred_q] = n;
          end
          cur_q = n;
          len_q = len_q + PTR_W'(1);
        end
      end
      OP_INS_RIGHT: begin
        // Stop check comes ahead of the pool-full check.
        if (cur_q == NIL && head_q != NIL) begin
          r.status = ST_AT_STOP;
        end else begin
          n = grab_node(e);
          if (n == NIL) begin
            r.status = ST_FULL;
          end else begin
            if (head_q != NIL) begin
              pool_next[n] = (cur_q != NIL) ? pool_next[cur_q] : NIL;
              if (cur_q != NIL) pool_next[cur_q] = n;
              pred_q = cur_q;
            end else begin
              head_q = n;
              pred_q = NIL;
            end
            cur_q = n;
            len_q = len_q + PTR_W'(1);
          end
        end
      end
      OP_ERASE: begin
        if (cur_q == NIL) begin
          r.status = ST_AT_STOP;
        end else begin
          n = cur_q;
          if (cur_q == head_q) begin
            head_q = pool_next[n];
            pred_q = NIL;
          end else if (pred_q != NIL) begin
            pool_next[pred_q] = pool_next[n];
          end
          cur_q        = pool_next[n];
          pool_next[n] = free_q;
          free_q       = n;
          if (len_q != '0) len_q = len_q - PTR_W'(1);
        end
      end
      OP_READ: begin
        if (cur_q == NIL) r.status = ST_AT_STOP;
      end
      default: ;
    endcase
    r.cur_elem = (cur_q != NIL) ? pool_val[cur_q] : 8'h00;
    r.length   = len_q;
    r.at_start = (cur_q == head_q);
    r.at_stop  = (cur_q == NIL);
    return r;
  endfunction

  function automatic logic [2:0] pick_op(cmd_mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 50) return OP_INS_LEFT;
        if (r < 75) return OP_INS_RIGHT;
        if (r < 85) return OP_STEP;
        if (r < 90) return OP_REWIND;
        if (r < 95) return OP_READ;
        return OP_ERASE;
      end
      MIX_SHRINK: begin
        if (r < 65) return OP_ERASE;
        if (r < 85) return OP_REWIND;
        if (r < 90) return OP_STEP;
        if (r < 95) return OP_READ;
        return OP_INS_LEFT;
      end
      MIX_NAV: begin
        if (r < 40) return OP_STEP;
        if (r < 55) return OP_REWIND;
        if (r < 80) return OP_READ;
        if (r < 88) return OP_INS_LEFT;
        if (r < 94) return OP_INS_RIGHT;
        return OP_ERASE;
      end
      default: begin
        if (r < 96) return 3'($urandom_range(0, 5));
        return r[0] ? OP_UNDEF_HI : OP_UNDEF_LO;
      end
    endcase
  endfunction

  // Present one command; return at the edge where it is taken.
  task automatic issue_cmd(input logic [2:0] op, input logic [7:0] e, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, e, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Receiver: random stalls per item, one long hold-off along the way.
  initial begin : report_sink
    int stall;
    int taken;
    int mode;
    taken = 0;
    mode  = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 32 == 0) mode = $urandom_range(0, 2);
      stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(mode);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    tape_report_t got;
    tape_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(tape_report_t)-1:0];
      if (tape_reports_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report: elem=%h status=%0d len=%0d start=%b stop=%b",
                   got.cur_elem, got.status, got.length, got.at_start, got.at_stop);
      end else begin
        want = tape_reports_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report mismatch: exp elem=%h status=%0d len=%0d start=%b stop=%b",
                     want.cur_elem, want.status, want.length, want.at_start,
                     want.at_stop,
                     " | got elem=%h status=%0d len=%0d start=%b stop=%b",
                     got.cur_elem, got.status, got.length,
                     got.at_start, got.at_stop);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** cursor_list_tape_engine_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : cmd_source
    tape_report_t predicted;
    logic [2:0]   op;
    logic [7:0]   e;
    int           sent;
    int           seg_len;
    int           mode;
    cmd_mix_t     mix;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    mode = 0;
    foreach (DIRECTED_ROWS[i]) begin
      issue_cmd(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].elem, draw_wait(i % 3));
      predicted = apply_tape_cmd(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].elem);
      tape_reports_q.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want : predicted);
    end

    // Fill the pool past exhaustion, drain it, then wander with mixed phases.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent == 0) begin
        mix     = MIX_GROW;
        seg_len = FILL_ITEMS;
      end else if (sent == FILL_ITEMS) begin
        mix     = MIX_SHRINK;
        seg_len = DRAIN_ITEMS;
      end else begin
        mix     = cmd_mix_t'($urandom_range(0, 3));
        seg_len = $urandom_range(40, 160);
      end
      for (int k = 0; k < seg_len && sent < RAND_ITEMS; k++) begin
        if (sent % 32 == 0) mode = $urandom_range(0, 2);
        op = pick_op(mix);
        e  = 8'($urandom_range(0, 255));
        issue_cmd(op, e, draw_wait(mode));
        tape_reports_q.push_back(apply_tape_cmd(op, e));
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (tape_reports_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** cursor_list_tape_engine_core: PASSED **");
    end else begin
      $display("** cursor_list_tape_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
